// ----- src/sst_pkg.sv -----
// Shared types and codes for the sparse set table.
package sst_pkg;

    localparam int KEY_W    = 10;
    localparam int CMD_W    = 3;
    localparam int ITEM_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 8;
    localparam int OCC_W    = 9;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RESET  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_COPY   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ABSENT  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  src_key;
        logic              has_data;
        logic [ITEM_W-1:0] item_data;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ITEM_W-1:0]   data_out;
        logic [SLOT_W-1:0]   slot;
        logic [OCC_W-1:0]    occupancy;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_KEYW,
        S_SRC,
        S_DATA,
        S_CPY,
        S_LAST,
        S_RMKEY,
        S_PUT
    } t_state;

endpackage

// ----- src/sparse_set_table.sv -----
// Sparse set table: key-to-slot map with packed slots and one data word per slot.
// After reset the key-to-slot store is swept clear, one entry a cycle, over
// min(KEY_SPACE, 1024) entries; no item is accepted during the sweep. After that an item
// is accepted only in idle. It passes through KEYW and PUT for add of a new key, reset,
// and any command other than copy on an absent key; through KEYW, DATA and PUT for get
// and add of a held key; through KEYW, SRC and PUT for copy into an absent key from an
// absent source; through KEYW, LAST, RMKEY and PUT for remove; through KEYW, SRC, CPY or
// DATA, and PUT for every other copy. The path follows the dependent lookups through the
// key, slot and data stores, each read registered. A finished result waits in an output
// register, so the next item is taken while the result is still stalled.
module sparse_set_table #(
    parameter int KEY_SPACE  = 1024,
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  sst_pkg::t_in_item    i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output sst_pkg::t_out_item   o_out_item,
    input  logic                 i_out_stall
);

    localparam int KDEPTH = (KEY_SPACE < 1024) ? KEY_SPACE : 1024;
    localparam int KIW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
    localparam int SIW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNW    = $clog2(CAPACITY + 1);
    localparam int DW     = DATA_WIDTH;

    logic [SIW:0]                 k2s_mem [KDEPTH];
    logic [sst_pkg::KEY_W-1:0]    s2k_mem [CAPACITY];
    logic [DW-1:0]                sd_mem  [CAPACITY];

    logic [SIW:0]                 k2s_q;
    logic [sst_pkg::KEY_W-1:0]    s2k_q;
    logic [DW-1:0]                sd_q;

    logic                         k2s_we;
    logic [KIW-1:0]               k2s_wa;
    logic [SIW:0]                 k2s_wd;
    logic [KIW-1:0]               k2s_ra;
    logic                         s2k_we;
    logic [SIW-1:0]               s2k_wa;
    logic [sst_pkg::KEY_W-1:0]    s2k_wd;
    logic [SIW-1:0]               s2k_ra;
    logic                         sd_we;
    logic [SIW-1:0]               sd_wa;
    logic [DW-1:0]                sd_wd;
    logic [SIW-1:0]               sd_ra;

    sst_pkg::t_state              r_state, n_state;
    logic [KIW-1:0]               r_clr;
    logic [CNW-1:0]               r_count, n_count;
    sst_pkg::t_in_item            r_item;
    logic                         r_was, n_was;
    logic [SIW-1:0]               r_kslot, n_kslot;
    logic [sst_pkg::STATUS_W-1:0] r_res_status, n_res_status;
    logic                         r_res_found, n_res_found;
    logic [DW-1:0]                r_res_data, n_res_data;
    logic [SIW-1:0]               r_res_slot, n_res_slot;
    logic                         r_ovalid;
    sst_pkg::t_out_item           r_out;

    logic                         in_xfer;
    logic                         out_free;
    logic                         key_ok;
    logic                         src_ok;
    logic                         was_now;
    logic                         src_held;
    logic                         full;
    logic [KIW-1:0]               key_idx;
    logic [KIW-1:0]               src_idx;
    logic [SIW-1:0]               cnt_slot;
    logic [SIW-1:0]               last_slot;
    logic [DW-1:0]                add_val;
    logic [63:0]                  item_ext;

    assign in_xfer   = i_in_valid && !o_in_stall;
    assign out_free  = !r_ovalid || !i_out_stall;
    assign key_ok    = 32'(r_item.key) < 32'(KEY_SPACE);
    assign src_ok    = 32'(r_item.src_key) < 32'(KEY_SPACE);
    assign was_now   = key_ok && k2s_q[SIW];
    assign src_held  = src_ok && k2s_q[SIW];
    assign full      = r_count == CNW'(CAPACITY);
    assign key_idx   = KIW'(r_item.key);
    assign src_idx   = KIW'(r_item.src_key);
    assign cnt_slot  = SIW'(r_count);
    assign last_slot = SIW'(r_count - CNW'(1));
    assign item_ext  = 64'(r_item.item_data);
    assign add_val   = r_item.has_data ? DW'(item_ext) : '0;

    assign o_in_stall  = r_state != sst_pkg::S_IDLE;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    // Stores: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (k2s_we) begin
            k2s_mem[k2s_wa] <= k2s_wd;
        end
        k2s_q <= k2s_mem[k2s_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s2k_we) begin
            s2k_mem[s2k_wa] <= s2k_wd;
        end
        s2k_q <= s2k_mem[s2k_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sd_we) begin
            sd_mem[sd_wa] <= sd_wd;
        end
        sd_q <= sd_mem[sd_ra];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sst_pkg::S_CLEAR: begin
                if (r_clr == KIW'(KDEPTH - 1)) begin
                    n_state = sst_pkg::S_IDLE;
                end
            end
            sst_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = sst_pkg::S_KEYW;
                end
            end
            sst_pkg::S_KEYW: begin
                case (r_item.cmd)
                    sst_pkg::CMD_ADD: begin
                        n_state = (key_ok && was_now) ? sst_pkg::S_DATA : sst_pkg::S_PUT;
                    end
                    sst_pkg::CMD_REMOVE: begin
                        n_state = was_now ? sst_pkg::S_LAST : sst_pkg::S_PUT;
                    end
                    sst_pkg::CMD_RESET: begin
                        n_state = sst_pkg::S_PUT;
                    end
                    sst_pkg::CMD_COPY: begin
                        n_state = sst_pkg::S_SRC;
                    end
                    default: begin
                        n_state = was_now ? sst_pkg::S_DATA : sst_pkg::S_PUT;
                    end
                endcase
            end
            sst_pkg::S_SRC: begin
                if (!src_held || !key_ok) begin
                    n_state = r_was ? sst_pkg::S_DATA : sst_pkg::S_PUT;
                end else begin
                    n_state = sst_pkg::S_CPY;
                end
            end
            sst_pkg::S_DATA:  n_state = sst_pkg::S_PUT;
            sst_pkg::S_CPY:   n_state = sst_pkg::S_PUT;
            sst_pkg::S_LAST:  n_state = sst_pkg::S_RMKEY;
            sst_pkg::S_RMKEY: n_state = sst_pkg::S_PUT;
            sst_pkg::S_PUT: begin
                if (out_free) begin
                    n_state = sst_pkg::S_IDLE;
                end
            end
            default: n_state = sst_pkg::S_IDLE;
        endcase
    end

    // Store control and result
    always_comb begin
        k2s_we       = 1'b0;
        k2s_wa       = key_idx;
        k2s_wd       = '0;
        k2s_ra       = key_idx;
        s2k_we       = 1'b0;
        s2k_wa       = cnt_slot;
        s2k_wd       = r_item.key;
        s2k_ra       = last_slot;
        sd_we        = 1'b0;
        sd_wa        = cnt_slot;
        sd_wd        = add_val;
        sd_ra        = r_kslot;
        n_count      = r_count;
        n_was        = r_was;
        n_kslot      = r_kslot;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_data   = r_res_data;
        n_res_slot   = r_res_slot;
        unique case (r_state)
            sst_pkg::S_CLEAR: begin
                k2s_we = 1'b1;
                k2s_wa = r_clr;
            end
            sst_pkg::S_IDLE: begin
                k2s_ra = KIW'(i_in_item.key);
            end
            sst_pkg::S_KEYW: begin
                n_was        = was_now;
                n_kslot      = k2s_q[SIW-1:0];
                n_res_found  = was_now;
                n_res_status = was_now ? sst_pkg::STAT_OK : sst_pkg::STAT_ABSENT;
                n_res_data   = '0;
                n_res_slot   = '0;
                sd_ra        = k2s_q[SIW-1:0];
                k2s_ra       = src_idx;
                case (r_item.cmd)
                    sst_pkg::CMD_ADD: begin
                        if (!key_ok) begin
                            n_res_status = sst_pkg::STAT_ABSENT;
                        end else if (was_now) begin
                            n_res_status = sst_pkg::STAT_PRESENT;
                        end else if (full) begin
                            n_res_status = sst_pkg::STAT_FULL;
                        end else begin
                            n_res_status = sst_pkg::STAT_OK;
                            sd_we        = 1'b1;
                            s2k_we       = 1'b1;
                            k2s_we       = 1'b1;
                            k2s_wd       = {1'b1, cnt_slot};
                            n_count      = r_count + CNW'(1);
                            n_res_data   = add_val;
                            n_res_slot   = cnt_slot;
                        end
                    end
                    sst_pkg::CMD_REMOVE: begin
                        sd_ra = last_slot;
                    end
                    sst_pkg::CMD_RESET: begin
                        if (was_now) begin
                            sd_we      = 1'b1;
                            sd_wa      = k2s_q[SIW-1:0];
                            sd_wd      = '0;
                            n_res_slot = k2s_q[SIW-1:0];
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sst_pkg::S_SRC: begin
                if (!src_held || !key_ok) begin
                    n_res_status = sst_pkg::STAT_ABSENT;
                    sd_ra        = r_kslot;
                end else begin
                    sd_ra = k2s_q[SIW-1:0];
                end
            end
            sst_pkg::S_DATA: begin
                n_res_data = sd_q;
                n_res_slot = r_kslot;
            end
            sst_pkg::S_CPY: begin
                sd_wd = sd_q;
                if (r_was) begin
                    sd_we        = 1'b1;
                    sd_wa        = r_kslot;
                    n_res_status = sst_pkg::STAT_OK;
                    n_res_data   = sd_q;
                    n_res_slot   = r_kslot;
                end else if (full) begin
                    n_res_status = sst_pkg::STAT_FULL;
                end else begin
                    n_res_status = sst_pkg::STAT_OK;
                    sd_we        = 1'b1;
                    s2k_we       = 1'b1;
                    k2s_we       = 1'b1;
                    k2s_wd       = {1'b1, cnt_slot};
                    n_count      = r_count + CNW'(1);
                    n_res_data   = sd_q;
                    n_res_slot   = cnt_slot;
                end
            end
            sst_pkg::S_LAST: begin
                sd_we  = 1'b1;
                sd_wa  = r_kslot;
                sd_wd  = sd_q;
                s2k_we = 1'b1;
                s2k_wa = r_kslot;
                s2k_wd = s2k_q;
                k2s_we = 1'b1;
                k2s_wa = KIW'(s2k_q);
                k2s_wd = {1'b1, r_kslot};
            end
            sst_pkg::S_RMKEY: begin
                k2s_we  = 1'b1;
                k2s_wd  = '0;
                n_count = r_count - CNW'(1);
            end
            sst_pkg::S_PUT: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sst_pkg::S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == sst_pkg::S_CLEAR) begin
                r_clr <= r_clr + KIW'(1);
            end
            if (r_state == sst_pkg::S_PUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item <= i_in_item;
        end
        r_was        <= n_was;
        r_kslot      <= n_kslot;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_data   <= n_res_data;
        r_res_slot   <= n_res_slot;
        if (r_state == sst_pkg::S_PUT && out_free) begin
            r_out.status    <= r_res_status;
            r_out.found     <= r_res_found;
            r_out.data_out  <= sst_pkg::ITEM_W'(64'(r_res_data));
            r_out.slot      <= sst_pkg::SLOT_W'(r_res_slot);
            r_out.occupancy <= sst_pkg::OCC_W'(r_count);
        end
    end

endmodule

// ----- tb/sparse_set_table_chk.sv -----
// Checker for the sparse set table: predicts each result and compares it with the block.
`timescale 1ns / 1ps

module sparse_set_table_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  sst_pkg::t_in_item  i_in_item,
    input  logic               i_in_stall,
    input  logic               i_out_valid,
    input  sst_pkg::t_out_item i_out_item,
    input  logic               i_out_stall,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam int KEY_SPACE = 1 << sst_pkg::KEY_W;
    localparam int CAPACITY  = 256;

    bit                         key_held   [KEY_SPACE];
    logic [sst_pkg::SLOT_W-1:0] key_slot   [KEY_SPACE];
    logic [sst_pkg::KEY_W-1:0]  slot_owner [CAPACITY];
    logic [sst_pkg::ITEM_W-1:0] slot_word  [CAPACITY];
    int unsigned                held_keys;

    sst_pkg::t_out_item expected_results[$];
    sst_pkg::t_out_item want;
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic logic [sst_pkg::STATUS_W-1:0] claim_slot(
            input logic [sst_pkg::KEY_W-1:0] k,
            input logic [sst_pkg::ITEM_W-1:0] value);
        logic [sst_pkg::SLOT_W-1:0] s;
        if (held_keys >= CAPACITY) begin
            return sst_pkg::STAT_FULL;
        end
        s = held_keys[sst_pkg::SLOT_W-1:0];
        slot_word[s]  = value;
        slot_owner[s] = k;
        key_slot[k]   = s;
        key_held[k]   = 1'b1;
        held_keys++;
        return sst_pkg::STAT_OK;
    endfunction

    function automatic sst_pkg::t_out_item run_command(input sst_pkg::t_in_item it);
        sst_pkg::t_out_item           res;
        logic [sst_pkg::STATUS_W-1:0] st;
        logic                         was;
        logic [sst_pkg::SLOT_W-1:0]   s;
        logic [sst_pkg::SLOT_W-1:0]   last;
        logic [sst_pkg::KEY_W-1:0]    moved_key;
        logic [sst_pkg::ITEM_W-1:0]   v;
        was = key_held[it.key];
        st  = sst_pkg::STAT_OK;
        case (it.cmd)
            sst_pkg::CMD_ADD: begin
                if (was) st = sst_pkg::STAT_PRESENT;
                else st = claim_slot(it.key, it.has_data ? it.item_data : '0);
            end
            sst_pkg::CMD_REMOVE: begin
                if (!was) begin
                    st = sst_pkg::STAT_ABSENT;
                end else begin
                    s         = key_slot[it.key];
                    last      = sst_pkg::SLOT_W'(held_keys - 1);
                    moved_key = slot_owner[last];
                    slot_word[s]        = slot_word[last];
                    slot_owner[s]       = moved_key;
                    key_slot[moved_key] = s;
                    key_held[it.key]    = 1'b0;
                    key_slot[it.key]    = '0;
                    held_keys--;
                end
            end
            sst_pkg::CMD_RESET: begin
                if (!was) st = sst_pkg::STAT_ABSENT;
                else slot_word[key_slot[it.key]] = '0;
            end
            sst_pkg::CMD_COPY: begin
                if (!key_held[it.src_key]) begin
                    st = sst_pkg::STAT_ABSENT;
                end else begin
                    v = slot_word[key_slot[it.src_key]];
                    if (was) slot_word[key_slot[it.key]] = v;
                    else st = claim_slot(it.key, v);
                end
            end
            default: begin
                if (!was) st = sst_pkg::STAT_ABSENT;
            end
        endcase
        res.status = st;
        res.found  = was;
        if (key_held[it.key]) begin
            res.data_out = slot_word[key_slot[it.key]];
            res.slot     = key_slot[it.key];
        end else begin
            res.data_out = '0;
            res.slot     = '0;
        end
        res.occupancy = sst_pkg::OCC_W'(held_keys);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [sst_pkg::ITEM_W-1:0] want_v,
                               input logic [sst_pkg::ITEM_W-1:0] got_v);
        if (want_v !== got_v) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (key_held[i]) key_held[i] = 1'b0;
            held_keys = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no result expected");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, i_out_item.status);
                    check_field("found", want.found, i_out_item.found);
                    check_field("data_out", want.data_out, i_out_item.data_out);
                    check_field("slot", want.slot, i_out_item.slot);
                    check_field("occupancy", want.occupancy, i_out_item.occupancy);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(run_command(i_in_item));
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ----- tb/sparse_set_table_tb.sv -----
// Testbench top for the sparse set table: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module sparse_set_table_tb;

    localparam int KEY_SPACE    = 1 << sst_pkg::KEY_W;
    localparam int CAPACITY     = 256;
    localparam int RANDOM_ITEMS = 1100;
    localparam int PHASE_LEN    = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int FULL_TRIES   = 12;

    localparam logic [sst_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 3'd5;
    localparam logic [sst_pkg::CMD_W-1:0] CMD_UNUSED_MID   = 3'd6;
    localparam logic [sst_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 3'd7;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    sst_pkg::t_in_item  in_item   = '0;
    logic               in_stall;
    logic               out_valid;
    sst_pkg::t_out_item out_item;
    logic               out_stall = 1'b0;

    int fail_count;
    int pending;
    int send_pct = 0;
    int recv_pct = 0;
    int quiet_cycles = 0;

    bit                tracked[KEY_SPACE];
    int                live_keys[$];
    bit                filling = 1'b1;
    int                full_tries = 0;
    sst_pkg::t_in_item directed[$];

    always #5 clk = ~clk;

    sparse_set_table u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    sparse_set_table_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_item    (in_item),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_item   (out_item),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        out_stall <= ($urandom_range(0, 99) < recv_pct);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("sparse_set_table test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic sst_pkg::t_in_item mk(input logic [sst_pkg::CMD_W-1:0] cmd,
                                             input int key, input int src, input bit has,
                                             input logic [sst_pkg::ITEM_W-1:0] data);
        sst_pkg::t_in_item it;
        it.cmd       = cmd;
        it.key       = sst_pkg::KEY_W'(key);
        it.src_key   = sst_pkg::KEY_W'(src);
        it.has_data  = has;
        it.item_data = data;
        return it;
    endfunction

    function automatic int pick_key(input bit prefer_live);
        if (prefer_live && live_keys.size() > 0 && $urandom_range(0, 99) < 85)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        return $urandom_range(0, KEY_SPACE - 1);
    endfunction

    function automatic sst_pkg::t_in_item next_random_item();
        sst_pkg::t_in_item it;
        int                r;
        int                add_pct;
        int                rm_pct;
        add_pct = filling ? 70 : 15;
        rm_pct  = filling ? 10 : 55;
        r = $urandom_range(0, 99);
        it.item_data = $urandom;
        it.has_data  = 1'($urandom_range(0, 1));
        it.src_key   = sst_pkg::KEY_W'(pick_key(1'b1));
        if (r < add_pct) begin
            it.cmd = sst_pkg::CMD_ADD;
            it.key = sst_pkg::KEY_W'(pick_key($urandom_range(0, 99) < 15));
        end else begin
            if (r < add_pct + rm_pct) it.cmd = sst_pkg::CMD_REMOVE;
            else if (r < add_pct + rm_pct + 10) it.cmd = sst_pkg::CMD_GET;
            else if (r < add_pct + rm_pct + 15) it.cmd = sst_pkg::CMD_RESET;
            else if (r < 99) it.cmd = sst_pkg::CMD_COPY;
            else it.cmd = CMD_UNUSED_FIRST + sst_pkg::CMD_W'($urandom_range(0, 2));
            it.key = sst_pkg::KEY_W'(pick_key(1'b1));
        end
        return it;
    endfunction

    task automatic track(input sst_pkg::t_in_item it);
        case (it.cmd)
            sst_pkg::CMD_ADD: begin
                if (!tracked[it.key] && live_keys.size() < CAPACITY) begin
                    tracked[it.key] = 1'b1;
                    live_keys.push_back(int'(it.key));
                end else if (!tracked[it.key]) begin
                    full_tries++;
                end
            end
            sst_pkg::CMD_COPY: begin
                if (tracked[it.src_key] && !tracked[it.key] && live_keys.size() < CAPACITY) begin
                    tracked[it.key] = 1'b1;
                    live_keys.push_back(int'(it.key));
                end
            end
            sst_pkg::CMD_REMOVE: begin
                if (tracked[it.key]) begin
                    tracked[it.key] = 1'b0;
                    for (int i = 0; i < live_keys.size(); i++) begin
                        if (live_keys[i] == int'(it.key)) begin
                            live_keys.delete(i);
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input sst_pkg::t_in_item it);
        while ($urandom_range(0, 99) < send_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        track(it);
        @(negedge clk);
    endtask

    // hold the sender until every expected result has come back
    task automatic wait_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    initial begin
        directed.push_back(mk(sst_pkg::CMD_GET, 0, 1023, 1'b1, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_REMOVE, 1023, 0, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_RESET, 512, 0, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_COPY, 3, 4, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_ADD, 0, 1023, 1'b1, 32'hFFFF_FFFF));
        directed.push_back(mk(sst_pkg::CMD_ADD, 1023, 0, 1'b0, 32'hFFFF_FFFF));
        directed.push_back(mk(sst_pkg::CMD_ADD, 0, 0, 1'b1, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_ADD, 5, 0, 1'b1, 32'hA5A5_A5A5));
        directed.push_back(mk(sst_pkg::CMD_GET, 1023, 0, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_RESET, 0, 0, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_COPY, 0, 5, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_COPY, 7, 5, 1'b1, 32'hFFFF_FFFF));
        directed.push_back(mk(sst_pkg::CMD_COPY, 5, 5, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_COPY, 9, 300, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_REMOVE, 0, 0, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_REMOVE, 7, 0, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_REMOVE, 1023, 0, 1'b0, 32'h0));
        directed.push_back(mk(CMD_UNUSED_FIRST, 5, 0, 1'b0, 32'h0));
        directed.push_back(mk(CMD_UNUSED_MID, 9, 0, 1'b1, 32'h1));
        directed.push_back(mk(CMD_UNUSED_LAST, 5, 1023, 1'b1, 32'hFFFF_FFFF));
        directed.push_back(mk(sst_pkg::CMD_REMOVE, 5, 0, 1'b0, 32'h0));
        directed.push_back(mk(sst_pkg::CMD_GET, 5, 0, 1'b0, 32'h0));

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        send_pct = 14;
        recv_pct = 55;
        foreach (directed[i]) send_item(directed[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == PHASE_LEN) begin
                wait_results();
                send_pct = 55;
                recv_pct = 14;
            end else if (n == 2 * PHASE_LEN) begin
                wait_results();
                send_pct = 0;
                recv_pct = 0;
            end
            send_item(next_random_item());
            if (filling && live_keys.size() == CAPACITY && full_tries >= FULL_TRIES) begin
                filling = 1'b0;
            end else if (!filling && live_keys.size() == 0) begin
                filling    = 1'b1;
                full_tries = 0;
            end
        end
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("sparse_set_table test passed");
        end else begin
            $display("sparse_set_table test failed");
        end
        $finish;
    end

endmodule
